@@ design/fidd_pkg.sv @@
// Shared types and constants of the free-fall, impact and drop detector.
package fidd_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FF_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMP_WIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMP_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 3'd4;

  localparam logic [CFG_W-1:0] FF_THR_RST   = 16'd350;
  localparam logic [CFG_W-1:0] FF_MIN_RST   = 16'd100;
  localparam logic [CFG_W-1:0] IMP_WIN_RST  = 16'd500;
  localparam logic [CFG_W-1:0] IMP_THR_RST  = 16'd2500;
  localparam logic [CFG_W-1:0] HOLDOFF_RST  = 16'd3000;

  localparam logic [15:0] MAG_MAX      = 16'hFFFF;
  localparam logic [12:0] DIV_RECIP    = 13'd5243;
  localparam int unsigned DIV_SHIFT    = 19;
  localparam logic [15:0] TENTHS_SAT   = 16'd25600;
  localparam logic [7:0]  TENTHS_MAX   = 8'd255;

  localparam int unsigned ROOT_STEPS = 16;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       acc_en;
    logic       root_init;
    logic       root_step;
    logic       track;
    logic       rule1;
    logic       rule2;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic free_fall;
    logic rule2_stop;
    logic held;
    logic out_free;
  } sts_t;

endpackage

@@ design/freefall_impact_drop_detector.sv @@
// Top level of the free-fall, impact and drop detector.
// A drop result becomes valid after its block-end item is accepted and goes through the steps
// (4 squaring, 16 root steps, 1 tracking, 3 rule states), later while the output is stalled.
// A new item is taken only in idle, after the last has left the 16-step square-root unit or,
// for a block end, the rule states; a drop waits in the last rule state till the output is free.
// Reset is asynchronous, active low; it restores register defaults, clears control and rule state.
module freefall_impact_drop_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [15:0]               accel_x_i,
  input  logic signed [15:0]               accel_y_i,
  input  logic signed [15:0]               accel_z_i,
  input  logic                             block_end_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             cfg_we_i,
  input  logic [fidd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fidd_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       impact_tenths_g_o
);
  import fidd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fidd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fidd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .block_end_i       (block_end_i),
    .now_ms_i          (now_ms_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .impact_tenths_g_o (impact_tenths_g_o)
  );

endmodule

@@ design/fidd_dp.sv @@
// Datapath: squares, square root, block trackers, drop rule state and result register.
module fidd_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fidd_pkg::cmd_t                   cmd_i,
  output fidd_pkg::sts_t                   sts_o,
  input  logic signed [15:0]               accel_x_i,
  input  logic signed [15:0]               accel_y_i,
  input  logic signed [15:0]               accel_z_i,
  input  logic                             block_end_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             cfg_we_i,
  input  logic [fidd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fidd_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       impact_tenths_g_o
);
  import fidd_pkg::*;

  logic [CFG_W-1:0] ff_thr_q, ff_min_q, imp_win_q, imp_thr_q, holdoff_q;

  logic signed [15:0] x_q, y_q, z_q;
  logic               end_q;
  logic [31:0]        now_q;

  logic signed [15:0] sq_op;
  logic signed [31:0] sq_full;
  logic [30:0]        prod_q;
  logic [31:0]        acc_q;

  logic [31:0] v_q;
  logic [19:0] rem_q;
  logic [18:0] racc_q;
  logic [18:0] racc_s;
  logic [19:0] rem_s;
  logic [15:0] mag;

  logic [15:0] min_q, max_q, new_min, new_max;
  logic [15:0] lo_q, hi_q;
  logic [28:0] div_q;

  logic        falling_q;
  logic [31:0] fst_q, fet_q, ldt_q;
  logic [31:0] el_start, el_end, el_drop;

  logic       out_valid_q;
  logic [7:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_thr_q  <= FF_THR_RST;
      ff_min_q  <= FF_MIN_RST;
      imp_win_q <= IMP_WIN_RST;
      imp_thr_q <= IMP_THR_RST;
      holdoff_q <= HOLDOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FF_THR:  ff_thr_q  <= cfg_data_i;
        REG_FF_MIN:  ff_min_q  <= cfg_data_i;
        REG_IMP_WIN: imp_win_q <= cfg_data_i;
        REG_IMP_THR: imp_thr_q <= cfg_data_i;
        REG_HOLDOFF: holdoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_op = x_q;
      2'd1:    sq_op = y_q;
      default: sq_op = z_q;
    endcase
  end
  assign sq_full = sq_op * sq_op;

  assign racc_s = {racc_q[17:0], 1'b0};
  assign rem_s  = {rem_q[17:0], v_q[31:30]};
  assign mag    = (|racc_q[18:17]) ? MAG_MAX : racc_q[16:1];

  assign new_min = (mag < min_q) ? mag : min_q;
  assign new_max = (mag > max_q) ? mag : max_q;

  assign el_start = now_q - fst_q;
  assign el_end   = now_q - fet_q;
  assign el_drop  = now_q - ldt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= accel_x_i;
      y_q   <= accel_y_i;
      z_q   <= accel_z_i;
      end_q <= block_end_i;
      now_q <= now_ms_i;
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {1'b0, prod_q};
    end
    if (cmd_i.sq_en) begin
      prod_q <= sq_full[30:0];
    end
    if (cmd_i.root_init) begin
      v_q    <= acc_q + {1'b0, prod_q};
      rem_q  <= '0;
      racc_q <= '0;
    end else if (cmd_i.root_step) begin
      v_q <= {v_q[29:0], 2'b00};
      if (racc_s < 19'(rem_s)) begin
        rem_q  <= rem_s - {1'b0, racc_s | 19'd1};
        racc_q <= racc_s + 19'd2;
      end else begin
        rem_q  <= rem_s;
        racc_q <= racc_s;
      end
    end
    if (cmd_i.track && end_q) begin
      lo_q <= new_min;
      hi_q <= new_max;
    end
    if (cmd_i.rule2) begin
      div_q <= 29'(hi_q) * 29'(DIV_RECIP);
    end
    if (cmd_i.emit) begin
      out_data_q <= (hi_q >= TENTHS_SAT) ? TENTHS_MAX : div_q[DIV_SHIFT+7:DIV_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MAG_MAX;
      max_q <= '0;
    end else if (cmd_i.track) begin
      if (end_q) begin
        min_q <= MAG_MAX;
        max_q <= '0;
      end else begin
        min_q <= new_min;
        max_q <= new_max;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falling_q <= 1'b0;
      fst_q     <= '0;
      fet_q     <= '0;
      ldt_q     <= '0;
    end else begin
      if (cmd_i.rule1) begin
        if (lo_q < ff_thr_q) begin
          if (!falling_q) begin
            falling_q <= 1'b1;
            fst_q     <= now_q;
          end
        end else if (falling_q) begin
          falling_q <= 1'b0;
          fet_q     <= (el_start >= 32'(ff_min_q)) ? now_q : '0;
        end
      end
      if (cmd_i.rule2 && fet_q != '0 && el_end > 32'(imp_win_q)) begin
        fet_q <= '0;
      end
      if (cmd_i.emit) begin
        ldt_q <= now_q;
        fet_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.block_end  = end_q;
  assign sts_o.free_fall  = lo_q < ff_thr_q;
  assign sts_o.rule2_stop = (fet_q == '0) || (el_end > 32'(imp_win_q)) || (hi_q < imp_thr_q);
  assign sts_o.held       = (ldt_q != '0) && (el_drop < 32'(holdoff_q));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign impact_tenths_g_o = out_data_q;

endmodule

@@ design/fidd_ctrl.sv @@
// Controller: sequences squaring, root steps, tracking and the drop rule for each item.
module fidd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output fidd_pkg::cmd_t cmd_o,
  input  fidd_pkg::sts_t sts_i
);
  import fidd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_TRACK = 3'd3;
  localparam logic [2:0] S_RULE1 = 3'd4;
  localparam logic [2:0] S_RULE2 = 3'd5;
  localparam logic [2:0] S_RULE3 = 3'd6;

  localparam logic [3:0] CNT_LAST = 4'(ROOT_STEPS - 1);
  localparam logic [3:0] SQ_LAST  = 4'd3;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_sel = cnt_q[1:0];
        cmd_o.sq_en  = (cnt_q != SQ_LAST);
        cmd_o.acc_en = (cnt_q != '0) && (cnt_q != SQ_LAST);
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == SQ_LAST) begin
          cmd_o.root_init = 1'b1;
          cnt_d           = '0;
          state_d         = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = S_TRACK;
        end
      end
      S_TRACK: begin
        cmd_o.track = 1'b1;
        state_d     = sts_i.block_end ? S_RULE1 : S_IDLE;
      end
      S_RULE1: begin
        cmd_o.rule1 = 1'b1;
        state_d     = sts_i.free_fall ? S_IDLE : S_RULE2;
      end
      S_RULE2: begin
        cmd_o.rule2 = 1'b1;
        state_d     = sts_i.rule2_stop ? S_IDLE : S_RULE3;
      end
      S_RULE3: begin
        if (sts_i.held) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SQ && cnt_q == '0))
    else $error("accepted item did not start squaring");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (sts_i.out_free && !sts_i.held && state_q == S_RULE3))
    else $error("result emitted into a busy output register");

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && cnt_q == CNT_LAST) |=> (state_q == S_TRACK))
    else $error("root iterations did not end in tracking");

  a_rule_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RULE1) |-> $past(state_q == S_TRACK && sts_i.block_end))
    else $error("drop rule ran without a block end");
`endif

endmodule
